// File: src/jfmp_pkg.sv
// ----------------------------------------------------------------------------
// jfmp_pkg
// Shared types and codes for the fuse-map stream parser: transfer payloads,
// event and error codes, and the characters the parser recognizes.
// ----------------------------------------------------------------------------
`default_nettype none

package jfmp_pkg;

    // fuse address width, fixed by the result payload
    localparam int unsigned FUSE_ADDR_BITS = 20;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_WRITE  = 3'd1;
    localparam logic [2:0] EV_CLEAR  = 3'd2;
    localparam logic [2:0] EV_FINISH = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CMD   = 3'd1;
    localparam logic [2:0] ERR_BAD_QLET  = 3'd2;
    localparam logic [2:0] ERR_NO_DIGIT  = 3'd3;
    localparam logic [2:0] ERR_FUSE_OVF  = 3'd4;
    localparam logic [2:0] ERR_NOT_BIT   = 3'd5;

    // characters
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_J  = 8'h4A;
    localparam logic [7:0] CH_UC_L  = 8'h4C;
    localparam logic [7:0] CH_UC_N  = 8'h4E;
    localparam logic [7:0] CH_UC_P  = 8'h50;
    localparam logic [7:0] CH_UC_Q  = 8'h51;
    localparam logic [7:0] CH_UC_V  = 8'h56;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    // input transfer payload
    typedef struct packed {
        logic [7:0] char_in;
        logic       stream_end;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [2:0]                event_res;
        logic [FUSE_ADDR_BITS-1:0] fuse_address;
        logic                      fuse_value;
        logic [2:0]                error_code;
        logic [FUSE_ADDR_BITS-1:0] fuse_count;
        logic [15:0]               pin_count;
        logic [15:0]               vector_count;
        logic [15:0]               arch_code;
        logic [15:0]               package_code;
        logic [7:0]                test_default;
        logic [15:0]               file_checksum;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/jedec_fuse_map_parser.sv
// ----------------------------------------------------------------------------
// jedec_fuse_map_parser
// Character-at-a-time parser for JEDEC fuse-map text, emitting fuse-write,
// clear-all, finished and error events plus the parsed header fields.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output side is ready and gives one
// result per byte. A byte passes an input register and a result register:
// the parser step on the held byte is registered into the result register,
// from which it transfers out. With the output side ready the block sustains
// one byte every cycle, limited by the parser state update (phase plus one
// decimal or hex accumulator step). Bytes before STX are skipped, CR and LF
// are ignored, ETX or stream_end finishes. After a finish or an error the
// block reports event none for every byte until reset; the error code stays
// latched. Decimal fields saturate, the checksum keeps its low 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module jedec_fuse_map_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  jfmp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output jfmp_pkg::t_out_item o_out_data
);

    localparam int unsigned AW = jfmp_pkg::FUSE_ADDR_BITS;
    // accumulator width covers both the fuse address and the 16-bit fields
    localparam int unsigned DW = (AW > 16) ? AW : 16;
    localparam logic [DW-1:0] ADDR_MAX = DW'({AW{1'b1}});
    localparam logic [DW-1:0] WORD_MAX = DW'(16'hFFFF);

    typedef enum logic [3:0] {
        PH_HEADER, PH_COMMAND, PH_NOTE, PH_CHECK, PH_QLETTER, PH_QF, PH_QP,
        PH_QV, PH_X, PH_JARCH, PH_JPKG, PH_LNUM, PH_LVAL, PH_FDEF, PH_DONE,
        PH_ERROR
    } t_phase;

    // decimal accumulate with saturation at max
    function automatic logic [DW-1:0] dec_push(
        input logic [DW-1:0] acc,
        input logic [7:0]    ch,
        input logic [DW-1:0] max
    );
        logic [DW+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (DW+4)'(ch[3:0]);
        if (v > {4'd0, max})
            return max;
        return v[DW-1:0];
    endfunction

    // control
    logic               r_in_valid;
    jfmp_pkg::t_in_item r_in;
    logic               r_out_valid;
    jfmp_pkg::t_out_item r_out;
    logic               adv;
    logic               take;

    // parser state
    t_phase        r_phase,      n_phase;
    logic [AW-1:0] r_cursor,     n_cursor;
    logic [AW-1:0] r_total,      n_total;
    logic [15:0]   r_pins,       n_pins;
    logic [15:0]   r_vectors,    n_vectors;
    logic [15:0]   r_arch,       n_arch;
    logic [15:0]   r_pkg,        n_pkg;
    logic [7:0]    r_test,       n_test;
    logic          r_defbit,     n_defbit;
    logic [15:0]   r_checksum,   n_checksum;
    logic [2:0]    r_error,      n_error;
    jfmp_pkg::t_out_item n_out;

    // handshake
    assign adv        = !r_out_valid || i_out_ready;
    assign take       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one parser step on the registered byte
    always_comb begin
        logic [7:0]    c;
        logic          is_dig;
        logic          is_blank;
        logic [3:0]    hexv;
        logic          is_hex;
        logic [2:0]    ev;
        logic [AW-1:0] addr;
        logic          val;

        c        = r_in.char_in;
        is_dig   = (c >= jfmp_pkg::CH_ZERO) && (c <= jfmp_pkg::CH_NINE);
        is_blank = c inside {jfmp_pkg::CH_SPACE, jfmp_pkg::CH_TAB,
                             jfmp_pkg::CH_VT, jfmp_pkg::CH_FF};
        hexv     = c[3:0];
        is_hex   = 1'b1;
        if (is_dig)
            hexv = c[3:0];
        else if (c inside {[jfmp_pkg::CH_LC_A:jfmp_pkg::CH_LC_F]}
                 || c inside {[jfmp_pkg::CH_UC_A:jfmp_pkg::CH_UC_F]})
            hexv = c[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        ev   = jfmp_pkg::EV_NONE;
        addr = '0;
        val  = 1'b0;

        n_phase    = r_phase;
        n_cursor   = r_cursor;
        n_total    = r_total;
        n_pins     = r_pins;
        n_vectors  = r_vectors;
        n_arch     = r_arch;
        n_pkg      = r_pkg;
        n_test     = r_test;
        n_defbit   = r_defbit;
        n_checksum = r_checksum;
        n_error    = r_error;

        if (r_phase == PH_DONE || r_phase == PH_ERROR) begin
            ev = jfmp_pkg::EV_NONE;
        end else if (r_in.stream_end || c == jfmp_pkg::CH_ETX) begin
            n_phase = PH_DONE;
            ev      = jfmp_pkg::EV_FINISH;
        end else if (c == jfmp_pkg::CH_CR || c == jfmp_pkg::CH_LF) begin
            ev = jfmp_pkg::EV_NONE;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (c == jfmp_pkg::CH_STX)
                        n_phase = PH_COMMAND;
                end
                PH_COMMAND: begin
                    case (c)
                        jfmp_pkg::CH_UC_N: n_phase = PH_NOTE;
                        jfmp_pkg::CH_UC_Q: n_phase = PH_QLETTER;
                        jfmp_pkg::CH_UC_F: n_phase = PH_FDEF;
                        jfmp_pkg::CH_UC_X: n_phase = PH_X;
                        jfmp_pkg::CH_UC_J: n_phase = PH_JARCH;
                        jfmp_pkg::CH_UC_C: n_phase = PH_CHECK;
                        jfmp_pkg::CH_UC_L: begin
                            n_phase  = PH_LNUM;
                            n_cursor = '0;
                        end
                        default: begin
                            n_error = jfmp_pkg::ERR_BAD_CMD;
                            n_phase = PH_ERROR;
                            ev      = jfmp_pkg::EV_ERROR;
                        end
                    endcase
                end
                PH_NOTE: begin
                    if (c == jfmp_pkg::CH_STAR)
                        n_phase = PH_COMMAND;
                end
                PH_CHECK: begin
                    if (c == jfmp_pkg::CH_STAR) begin
                        n_phase = PH_COMMAND;
                    end else if (is_hex) begin
                        n_checksum = {r_checksum[11:0], hexv};
                    end else begin
                        n_error = jfmp_pkg::ERR_NO_DIGIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_QLETTER: begin
                    if (c == jfmp_pkg::CH_UC_F) begin
                        n_phase = PH_QF;
                    end else if (c == jfmp_pkg::CH_UC_P) begin
                        n_phase = PH_QP;
                    end else if (c == jfmp_pkg::CH_UC_V) begin
                        n_phase = PH_QV;
                    end else begin
                        n_error = jfmp_pkg::ERR_BAD_QLET;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_QF, PH_QP, PH_QV, PH_JPKG: begin
                    if (is_dig) begin
                        case (r_phase)
                            PH_QF: n_total = AW'(dec_push(DW'(r_total), c, ADDR_MAX));
                            PH_QP: n_pins = 16'(dec_push(DW'(r_pins), c, WORD_MAX));
                            PH_QV: n_vectors =
                                16'(dec_push(DW'(r_vectors), c, WORD_MAX));
                            default: n_pkg = 16'(dec_push(DW'(r_pkg), c, WORD_MAX));
                        endcase
                    end else if (c == jfmp_pkg::CH_STAR) begin
                        n_phase = PH_COMMAND;
                    end else begin
                        n_error = jfmp_pkg::ERR_NO_DIGIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_X: begin
                    if (c == jfmp_pkg::CH_STAR)
                        n_phase = PH_COMMAND;
                    else
                        n_test = c - jfmp_pkg::CH_ZERO;
                end
                PH_JARCH: begin
                    if (is_dig) begin
                        n_arch = 16'(dec_push(DW'(r_arch), c, WORD_MAX));
                    end else if (c == jfmp_pkg::CH_SPACE) begin
                        n_phase = PH_JPKG;
                    end else begin
                        n_error = jfmp_pkg::ERR_NO_DIGIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_LNUM: begin
                    if (is_dig) begin
                        n_cursor = AW'(dec_push(DW'(r_cursor), c, ADDR_MAX));
                    end else if (is_blank) begin
                        n_phase = PH_LVAL;
                    end else begin
                        n_error = jfmp_pkg::ERR_NO_DIGIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_LVAL: begin
                    if (c == jfmp_pkg::CH_STAR) begin
                        n_phase = PH_COMMAND;
                    end else if (is_blank) begin
                        ev = jfmp_pkg::EV_NONE;
                    end else if (r_cursor >= r_total) begin
                        n_error = jfmp_pkg::ERR_FUSE_OVF;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end else if (c == jfmp_pkg::CH_ZERO || c == jfmp_pkg::CH_ONE) begin
                        ev       = jfmp_pkg::EV_WRITE;
                        addr     = r_cursor;
                        val      = c[0];
                        n_cursor = r_cursor + AW'(1);
                    end else begin
                        n_error = jfmp_pkg::ERR_NOT_BIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                PH_FDEF: begin
                    if (c == jfmp_pkg::CH_ZERO || c == jfmp_pkg::CH_ONE) begin
                        n_defbit = c[0];
                    end else if (c == jfmp_pkg::CH_STAR) begin
                        n_phase = PH_COMMAND;
                        ev      = jfmp_pkg::EV_CLEAR;
                        val     = r_defbit;
                    end else begin
                        n_error = jfmp_pkg::ERR_NOT_BIT;
                        n_phase = PH_ERROR;
                        ev      = jfmp_pkg::EV_ERROR;
                    end
                end
                default: n_phase = PH_ERROR;
            endcase
        end

        n_out.event_res     = ev;
        n_out.fuse_address  = addr;
        n_out.fuse_value    = val;
        n_out.error_code    = n_error;
        n_out.fuse_count    = n_total;
        n_out.pin_count     = n_pins;
        n_out.vector_count  = n_vectors;
        n_out.arch_code     = n_arch;
        n_out.package_code  = n_pkg;
        n_out.test_default  = n_test;
        n_out.file_checksum = n_checksum;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_cursor    <= '0;
            r_total     <= '0;
            r_pins      <= '0;
            r_vectors   <= '0;
            r_arch      <= '0;
            r_pkg       <= '0;
            r_test      <= '0;
            r_defbit    <= 1'b0;
            r_checksum  <= '0;
            r_error     <= jfmp_pkg::ERR_NONE;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (take) begin
                r_phase    <= n_phase;
                r_cursor   <= n_cursor;
                r_total    <= n_total;
                r_pins     <= n_pins;
                r_vectors  <= n_vectors;
                r_arch     <= n_arch;
                r_pkg      <= n_pkg;
                r_test     <= n_test;
                r_defbit   <= n_defbit;
                r_checksum <= n_checksum;
                r_error    <= n_error;
            end
        end
        if (take) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // an error event always carries a latched error code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == jfmp_pkg::EV_ERROR)
        |-> (o_out_data.error_code != jfmp_pkg::ERR_NONE))
        else $error("error event without error code");

    // fuse writes stay inside the declared fuse count
    a_fuse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == jfmp_pkg::EV_WRITE)
        |-> (o_out_data.fuse_address < o_out_data.fuse_count))
        else $error("fuse write beyond fuse count");

    // error phase is left only by reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("left error phase without reset");

    // a held input byte blocks the next transfer while the result stalls
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline stalled");
`endif

endmodule

`default_nettype wire
